// File: src/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

    localparam int DEQ_DEPTH      = 16;
    localparam int DEQ_DATA_WIDTH = 32;
    localparam int CMDQ_DEPTH     = 2;

    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 4;
    localparam int COMMAND_W  = 3;
    localparam int COUNT_W    = 5;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_READ       = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic                 wr;
        logic                 rd;
        status_t              status;
        logic [COUNT_W-1:0]   count;
    } ctl_t;

endpackage

// File: src/deq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/deq_front.sv
// Command intake: classifies each request and updates the ring pointers and count.
module deq_front #(
    parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [deq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic [deq_pkg::COMMAND_W-1:0]     s_axis_tuser,
    output logic                              op_valid,
    input  logic                              op_ready,
    output deq_pkg::ctl_t                     op_ctl,
    output logic [$clog2(DEPTH)-1:0]          op_addr,
    output logic [DATA_WIDTH-1:0]             op_wdata
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   SLOTS = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL  = CW'(DEPTH);

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;

    logic                   accept;
    logic [COMMAND_W-1:0]   cmd;
    logic signed [VALUE_W-1:0] value;
    logic [POSITION_W-1:0]  pos;
    logic                   is_full;
    logic                   is_empty;
    logic [AW-1:0]          front_dec;
    status_t                status;
    logic                   wr;
    logic                   rd;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= SLOTS)
        begin
            sum = sum - SLOTS;
        end
        return sum[AW-1:0];
    endfunction

    assign cmd      = s_axis_tuser;
    assign value    = s_axis_tdata[VALUE_W-1:0];
    assign pos      = s_axis_tdata[VALUE_W+POSITION_W-1:VALUE_W];
    assign is_full  = (count_reg == FULL);
    assign is_empty = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? LAST : front_reg - AW'(1);

    assign accept        = s_axis_tvalid && op_ready;
    assign s_axis_tready = op_ready;
    assign op_valid      = s_axis_tvalid;

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        status     = ST_OK;
        wr         = 1'b0;
        rd         = 1'b0;
        op_addr    = front_reg;
        case (cmd)
            CMD_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    wr         = 1'b1;
                    op_addr    = front_dec;
                    front_next = front_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    wr         = 1'b1;
                    op_addr    = wrap_add(front_reg, AW'(count_reg));
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    rd         = 1'b1;
                    op_addr    = front_reg;
                    front_next = wrap_add(front_reg, AW'(1));
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_POP_BACK:
            begin
                if (is_empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    rd         = 1'b1;
                    op_addr    = wrap_add(front_reg, AW'(count_reg - CW'(1)));
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_READ:
            begin
                if ((CW + POSITION_W)'(pos) >= (CW + POSITION_W)'(count_reg))
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    rd      = 1'b1;
                    op_addr = wrap_add(front_reg, AW'(pos));
                end
            end
            default:
            begin
            end
        endcase
    end

    assign op_ctl.wr     = wr;
    assign op_ctl.rd     = rd;
    assign op_ctl.status = status;
    assign op_ctl.count  = COUNT_W'(count_next);
    assign op_wdata      = DATA_WIDTH'(value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("entry count exceeds depth");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (AW + 1)'(front_reg) < SLOTS)
        else $error("front index outside ring");
`endif

endmodule

// File: src/deq_cmdq.sv
// Short queue of classified requests between intake and execution.
module deq_cmdq #(
    parameter int WIDTH = 8,
    parameter int DEPTH = deq_pkg::CMDQ_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PLAST = PW'(DEPTH - 1);
    localparam logic [NW-1:0] NFULL = NW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    fill_reg, fill_next;
    logic             push;
    logic             pop;

    assign in_ready  = (fill_reg != NFULL);
    assign out_valid = (fill_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PLAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PLAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// File: src/deq_back.sv
// Request execution: performs the storage access and holds the result for the output.
module deq_back #(
    parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op_valid,
    output logic                          op_ready,
    input  deq_pkg::ctl_t                 op_ctl,
    input  logic [$clog2(DEPTH)-1:0]      op_addr,
    input  logic [DATA_WIDTH-1:0]         op_wdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [deq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [1:0]                    m_axis_tuser
);
    import deq_pkg::*;

    typedef enum logic [2:0] {
        ST_TAKE = 3'b001,
        ST_READ = 3'b010,
        ST_HOLD = 3'b100
    } bstate_t;

    bstate_t state_reg, state_next;
    ctl_t    ctl_reg;
    logic [VALUE_W-1:0] data_reg;

    logic                          take;
    logic [DATA_WIDTH-1:0]         rdata;
    logic signed [DATA_WIDTH-1:0]  rdata_s;

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (take && op_ctl.wr),
        .waddr (op_addr),
        .wdata (op_wdata),
        .raddr (op_addr),
        .rdata (rdata)
    );

    assign rdata_s  = rdata;
    assign take     = op_valid &&
                      ((state_reg == ST_TAKE) || ((state_reg == ST_HOLD) && m_axis_tready));
    assign op_ready = take;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_TAKE:
            begin
                if (take)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (take)
                begin
                    state_next = ST_READ;
                end
                else if (m_axis_tready)
                begin
                    state_next = ST_TAKE;
                end
            end
            default:
            begin
                state_next = ST_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ctl_reg <= op_ctl;
        end
        if (state_reg == ST_READ)
        begin
            data_reg <= ctl_reg.rd ? VALUE_W'(rdata_s) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_TAKE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign m_axis_tvalid = (state_reg == ST_HOLD);
    assign m_axis_tdata  = {(OUT_DATA_W - VALUE_W - COUNT_W)'(0), ctl_reg.count, data_reg};
    assign m_axis_tuser  = ctl_reg.status;

`ifndef NO_ASSERTIONS
    a_read_then_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_HOLD))
        else $error("result not presented after storage read");

    a_take_not_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (state_reg != ST_READ))
        else $error("request taken during storage read");

    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_HOLD) && !ctl_reg.rd) |-> (data_reg == '0))
        else $error("nonzero data on request without read");
`endif

endmodule

// File: src/double_ended_queue_top.sv
// Top level of the bounded double-ended queue.
//
// Slave channel s_axis carries one request per handshake: tuser holds the
// command (push front, push back, pop front, pop back, read position), tdata
// holds the word to push and the position to read. Master channel m_axis
// returns exactly one result per request, in request order: tdata holds the
// popped or read word (0 on push or error) and the count after the request,
// tuser holds the status (ok, empty, out of range, full).
// The intake updates ring pointers and count in the cycle a request is
// accepted and can take one request per cycle until the two-entry request
// queue fills. The execution side takes a request, reads storage, then
// holds the result, so it cannot take a new request during the read; it
// can take the next one while holding. After acceptance a request passes
// through the request queue and then the take, read and hold states.
// Reset clears pointers, count and all handshake state; stored words are
// undefined until pushed and no clearing pass runs. When the receiver stalls,
// the result holds in its output register while the intake keeps accepting
// requests until the request queue is full.
module double_ended_queue_top #(
    parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // value [31:0], position [35:32], zero fill [39:36]
    input  logic [deq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // command [2:0]
    input  logic [deq_pkg::COMMAND_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // data [31:0], count [36:32], zero fill [39:37]
    output logic [deq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status [1:0]
    output logic [1:0]                     m_axis_tuser
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int QW = $bits(ctl_t) + AW + DATA_WIDTH;

    logic                  f_valid;
    logic                  f_ready;
    ctl_t                  f_ctl;
    logic [AW-1:0]         f_addr;
    logic [DATA_WIDTH-1:0] f_wdata;

    logic                  b_valid;
    logic                  b_ready;
    logic [QW-1:0]         b_data;
    ctl_t                  b_ctl;
    logic [AW-1:0]         b_addr;
    logic [DATA_WIDTH-1:0] b_wdata;

    deq_front #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .op_valid      (f_valid),
        .op_ready      (f_ready),
        .op_ctl        (f_ctl),
        .op_addr       (f_addr),
        .op_wdata      (f_wdata)
    );

    deq_cmdq #(
        .WIDTH (QW),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_ctl, f_addr, f_wdata}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    assign {b_ctl, b_addr, b_wdata} = b_data;

    deq_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .op_valid      (b_valid),
        .op_ready      (b_ready),
        .op_ctl        (b_ctl),
        .op_addr       (b_addr),
        .op_wdata      (b_wdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
